@@ hw/rtl/gstr_pkg.sv @@
// Shared types, constants and a helper function for the Gardner timing recovery block.
package gstr_pkg;

    // Field and position widths.
    localparam int SAMPLE_BITS   = 16;
    localparam int POS_FRAC_BITS = 16;
    localparam int TIME_BITS     = 32;

    localparam int STEP_W  = 8 + POS_FRAC_BITS;
    localparam int RANGE_W = 7 + POS_FRAC_BITS;
    localparam int GAIN_W  = 8 + POS_FRAC_BITS;
    localparam int OFS_W   = POS_FRAC_BITS + 16;

    localparam int CFG_DATA_W = STEP_W;
    localparam int CFG_IDX_W  = 2;

    // Shared multiplier and error datapath widths.
    localparam int MUL_A_W = (GAIN_W > SAMPLE_BITS) ? GAIN_W : SAMPLE_BITS;
    localparam int MUL_B_W = SAMPLE_BITS;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int MAG_W   = 2 * SAMPLE_BITS - 1;
    localparam int ACC_W   = GAIN_W + MAG_W;
    localparam int RSH     = 2 * (SAMPLE_BITS - 1);
    localparam int Q_W     = ACC_W - RSH;
    localparam int QR_W    = Q_W + 1;

    // Position constants: one sample and half a sample.
    localparam logic signed [OFS_W-1:0] POS_ONE  = OFS_W'(64'd1 << POS_FRAC_BITS);
    localparam logic signed [OFS_W-1:0] POS_HALF = OFS_W'(64'd1 << (POS_FRAC_BITS - 1));

    // Register reset values.
    localparam logic [STEP_W-1:0]  STEP_SIZE_RST  = STEP_W'(188972);
    localparam logic [RANGE_W-1:0] STEP_RANGE_RST = RANGE_W'(32768);
    localparam logic [GAIN_W-1:0]  LOOP_GAIN_RST  = GAIN_W'(32768);

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RANGE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_GAIN  = CFG_IDX_W'(2);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_value;
        logic [TIME_BITS-1:0]          sample_time;
    } gstr_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] symbol_value;
        logic [TIME_BITS-1:0]          symbol_time;
    } gstr_out_t;

    typedef struct packed {
        logic [STEP_W-1:0]  step_size;
        logic [RANGE_W-1:0] step_range;
        logic [GAIN_W-1:0]  loop_gain;
    } gstr_cfg_t;

    // Core status toward the handshake logic.
    typedef struct packed {
        logic idle;
        logic emit;
    } gstr_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAG,
        ST_LO,
        ST_HI,
        ST_ACC,
        ST_ROUND,
        ST_CLAMP,
        ST_UPDATE
    } gstr_state_t;

    // True when a position rounds to the current sample.
    function automatic logic at_current(input logic signed [OFS_W-1:0] pos);
        return (pos >= -POS_HALF) && (pos <= POS_HALF);
    endfunction

endpackage

@@ hw/rtl/gstr_cfg_regs.sv @@
// Configuration registers of the timing recovery loop.
module gstr_cfg_regs
    import gstr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output gstr_cfg_t             cfg
);

    gstr_cfg_t cfg_reg;

    // Each write lands in the addressed register, masked to its width.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_size  <= STEP_SIZE_RST;
            cfg_reg.step_range <= STEP_RANGE_RST;
            cfg_reg.loop_gain  <= LOOP_GAIN_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_STEP_SIZE:  cfg_reg.step_size  <= cfg_wdata[STEP_W-1:0];
                CFG_STEP_RANGE: cfg_reg.step_range <= cfg_wdata[RANGE_W-1:0];
                CFG_LOOP_GAIN:  cfg_reg.loop_gain  <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/gstr_mul.sv @@
// Shared unsigned multiplier with a registered product.
module gstr_mul
    import gstr_pkg::*;
(
    input  logic               aclk,
    input  logic [MUL_A_W-1:0] op_a,
    input  logic [MUL_B_W-1:0] op_b,
    output logic [MUL_P_W-1:0] prod
);

    logic [MUL_P_W-1:0] prod_reg;

    // The product is registered and ready in the cycle after the operands are presented.
    always_ff @(posedge aclk) begin
        prod_reg <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

@@ hw/rtl/gstr_core.sv @@
// Position tracking, mid-sample latch and the sequenced Gardner error datapath.
module gstr_core
    import gstr_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gstr_cfg_t                     cfg,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output gstr_status_t                  status
);

    gstr_state_t state_reg, state_next;

    logic signed [OFS_W-1:0]       sym_reg;
    logic signed [OFS_W-1:0]       mid_reg;
    logic signed [SAMPLE_BITS-1:0] prev_reg;
    logic signed [SAMPLE_BITS-1:0] mid_sample_reg;

    logic signed [SAMPLE_BITS-1:0] cur_reg;
    logic                          neg_reg;
    logic [SAMPLE_BITS-2:0]        magh_reg;
    logic [ACC_W-1:0]              acc_reg;
    logic [QR_W-1:0]               q_reg;
    logic signed [OFS_W-1:0]       base_reg;

    logic [MUL_A_W-1:0] op_a;
    logic [MUL_B_W-1:0] op_b;
    logic [MUL_P_W-1:0] prod;

    logic                          emit;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [SAMPLE_BITS:0]   mid_wide;
    logic [SAMPLE_BITS:0]          diff_abs;
    logic [SAMPLE_BITS:0]          mid_abs;
    logic [Q_W-1:0]                q_trunc;
    logic                          round_up;
    logic [RANGE_W-1:0]            q_clamped;
    logic signed [OFS_W-1:0]       q_ext;
    logic signed [OFS_W-1:0]       step_m1;
    logic signed [OFS_W-1:0]       sym_cand;
    logic signed [OFS_W-1:0]       mid_pos;

    gstr_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // A symbol is due when its position rounds to the current sample or earlier.
    assign emit = (sym_reg <= POS_HALF);

    assign status.idle = (state_reg == ST_IDLE);
    assign status.emit = emit;

    // Sample difference and magnitudes for the first product.
    assign diff     = $signed({cur_reg[SAMPLE_BITS-1], cur_reg})
                    - $signed({prev_reg[SAMPLE_BITS-1], prev_reg});
    assign mid_wide = $signed({mid_sample_reg[SAMPLE_BITS-1], mid_sample_reg});
    assign diff_abs = diff[SAMPLE_BITS] ? unsigned'(-diff) : unsigned'(diff);
    assign mid_abs  = mid_wide[SAMPLE_BITS] ? unsigned'(-mid_wide) : unsigned'(mid_wide);

    // Round to nearest, ties to even, after dropping the sample fraction bits.
    assign q_trunc  = acc_reg[ACC_W-1:RSH];
    assign round_up = acc_reg[RSH-1] && ((|acc_reg[RSH-2:0]) || q_trunc[0]);

    // Clamp the correction and apply its sign.
    assign q_clamped = (q_reg > QR_W'(cfg.step_range)) ? cfg.step_range
                                                      : q_reg[RANGE_W-1:0];
    assign q_ext     = $signed(OFS_W'(q_clamped));

    // New positions; the symbol position is floored at the current sample.
    assign step_m1  = $signed(OFS_W'(cfg.step_size)) - POS_ONE;
    assign sym_cand = base_reg + step_m1;
    assign mid_pos  = base_reg + $signed(OFS_W'(cfg.step_size >> 1));

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (start && emit) state_next = ST_MAG;
            ST_MAG:    state_next = ST_LO;
            ST_LO:     state_next = ST_HI;
            ST_HI:     state_next = ST_ACC;
            ST_ACC:    state_next = ST_ROUND;
            ST_ROUND:  state_next = ST_CLAMP;
            ST_CLAMP:  state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Multiplier operands for each step.
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            ST_MAG: begin
                op_a = MUL_A_W'(diff_abs[SAMPLE_BITS-1:0]);
                op_b = mid_abs[SAMPLE_BITS-1:0];
            end
            ST_LO: begin
                op_a = MUL_A_W'(cfg.loop_gain);
                op_b = prod[SAMPLE_BITS-1:0];
            end
            ST_HI: begin
                op_a = MUL_A_W'(cfg.loop_gain);
                op_b = MUL_B_W'(magh_reg);
            end
            default: ;
        endcase
    end

    // Loop state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            sym_reg        <= '0;
            mid_reg        <= '0;
            prev_reg       <= '0;
            mid_sample_reg <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        if (at_current(mid_reg)) begin
                            mid_sample_reg <= sample;
                        end
                        if (!emit) begin
                            sym_reg <= sym_reg - POS_ONE;
                            mid_reg <= mid_reg - POS_ONE;
                        end
                    end
                end
                ST_UPDATE: begin
                    prev_reg <= cur_reg;
                    sym_reg  <= (sym_cand < -POS_ONE) ? -POS_ONE : sym_cand;
                    mid_reg  <= mid_pos - POS_ONE;
                    if (at_current(mid_pos)) begin
                        mid_sample_reg <= cur_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // Error datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    cur_reg <= sample;
                end
            end
            ST_MAG: begin
                neg_reg <= diff[SAMPLE_BITS] ^ mid_wide[SAMPLE_BITS];
            end
            ST_LO: begin
                magh_reg <= prod[MAG_W-1:SAMPLE_BITS];
            end
            ST_HI: begin
                acc_reg <= ACC_W'(prod[GAIN_W+SAMPLE_BITS-1:0]);
            end
            ST_ACC: begin
                acc_reg <= acc_reg + {prod[GAIN_W+SAMPLE_BITS-2:0], {SAMPLE_BITS{1'b0}}};
            end
            ST_ROUND: begin
                q_reg <= QR_W'(q_trunc) + QR_W'(round_up);
            end
            ST_CLAMP: begin
                base_reg <= neg_reg ? (sym_reg + q_ext) : (sym_reg - q_ext);
            end
            default: ;
        endcase
    end

endmodule

@@ hw/rtl/gardner_symbol_timing_recovery.sv @@
// Top level of the Gardner symbol timing recovery block.
//
// Samples arrive on the s_ channel (valid/ready) with a timestamp. The block
// keeps the next symbol position and the mid-symbol position relative to the
// current sample. When a symbol is due, the current sample and its time are
// loaded into the output register at the input transfer and offered on the
// m_ channel in the cycle after acceptance.
// A sample that produces no symbol leaves the core idle, and the next sample may
// follow in the next cycle. A symbol sample starts the error sequence on the
// shared multiplier: three products, accumulate, round, clamp and position
// update, so the input is not ready until the sequence is back in idle.
// If the receiver stalls, samples that produce no symbol are still taken;
// the next symbol sample waits until the output register is free.
// Reset (aresetn, synchronous, active low) clears the positions, the
// previous symbol and the mid sample, empties the output register and
// restores the configuration registers to their defaults. Configuration
// writes take effect at once and belong to idle periods.
module gardner_symbol_timing_recovery
    import gstr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  gstr_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output gstr_out_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    gstr_cfg_t    cfg;
    gstr_status_t status;
    logic         in_fire;
    logic         m_valid_reg;
    gstr_out_t    m_data_reg;

    gstr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    gstr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .start   (in_fire),
        .sample  (s_data.sample_value),
        .status  (status)
    );

    // A symbol sample needs room in the output register; others always fit.
    assign s_ready = status.idle && (!status.emit || !m_valid_reg || m_ready);
    assign in_fire = s_valid && s_ready;

    // Output register: loaded on a symbol transfer, emptied when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire && status.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && status.emit) begin
            m_data_reg.symbol_value <= s_data.sample_value;
            m_data_reg.symbol_time  <= s_data.sample_time;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
